// File: design/des_round_key_generator_core_defines.svh
// Assertion macros shared by the DES round key generator modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef DES_ROUND_KEY_GENERATOR_CORE_DEFINES_SVH
`define DES_ROUND_KEY_GENERATOR_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DRKG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DRKG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/des_rkg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round key generator package
// Transaction types, table constants and permutation helpers.
// ----------------------------------------------------------------------------
package des_rkg_pkg;

    localparam int KEY_W  = 64;
    localparam int HALF_W = 28;
    localparam int CD_W   = 56;
    localparam int RK_W   = 48;
    localparam int ROUNDS = 16;
    localparam int IDX_W  = 4;

    typedef logic [IDX_W-1:0]  round_idx_t;
    typedef logic [HALF_W-1:0] half_t;

    localparam round_idx_t LAST_ROUND = round_idx_t'(ROUNDS - 1);

    // Bit i is set where round i rotates by two places.
    localparam logic [ROUNDS-1:0] DOUBLE_SHIFT = 16'h7EFC;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             decrypt;
    } key_item_t;

    typedef struct packed {
        logic [RK_W-1:0] round_key;
        round_idx_t      round_index;
        logic            last;
    } subkey_item_t;

    typedef struct packed {
        half_t c;
        half_t d;
        logic  decrypt;
    } halves_t;

    localparam int PC1_TAB [CD_W] = '{
        57, 49, 41, 33, 25, 17,  9,
         1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27,
        19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
         7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29,
        21, 13,  5, 28, 20, 12,  4
    };

    localparam int PC2_TAB [RK_W] = '{
        14, 17, 11, 24,  1,  5,
         3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8,
        16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] cd;
        cd = '0;
        for (int i = 0; i < CD_W; i++)
        begin
            cd[CD_W-1-i] = key[KEY_W-PC1_TAB[i]];
        end
        return cd;
    endfunction

    function automatic logic [RK_W-1:0] pc2(input logic [CD_W-1:0] cd);
        logic [RK_W-1:0] rk;
        rk = '0;
        for (int i = 0; i < RK_W; i++)
        begin
            rk[RK_W-1-i] = cd[CD_W-PC2_TAB[i]];
        end
        return rk;
    endfunction

    function automatic half_t rot_left(input half_t x, input logic by_two);
        return by_two ? {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]}
                      : {x[HALF_W-2:0], x[HALF_W-1]};
    endfunction

    function automatic half_t rot_right(input half_t x, input logic by_two);
        return by_two ? {x[1:0], x[HALF_W-1:2]}
                      : {x[0], x[HALF_W-1:1]};
    endfunction

endpackage

// File: design/des_rkg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round key generator front end
// Accepts key transactions, applies PC-1 and hands the halves to the queue.
// ----------------------------------------------------------------------------
module des_rkg_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_stall,
    input  des_rkg_pkg::key_item_t key_data,
    output logic                  push,
    input  logic                  queue_full,
    output des_rkg_pkg::halves_t   push_data
);
    import des_rkg_pkg::*;

    logic            held_reg;
    halves_t         halves_reg;
    logic            accept;
    logic [CD_W-1:0] cd;

    assign key_stall = held_reg && queue_full;
    assign accept    = key_valid && !key_stall;
    assign push      = held_reg && !queue_full;
    assign push_data = halves_reg;
    assign cd        = pc1(key_data.key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= 1'b1;
        end
        else if (push)
        begin
            held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            halves_reg.c       <= cd[CD_W-1:HALF_W];
            halves_reg.d       <= cd[HALF_W-1:0];
            halves_reg.decrypt <= key_data.decrypt;
        end
    end

endmodule

// File: design/des_rkg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round key generator queue
// Small first-in first-out buffer of PC-1 halves between front and back.
// ----------------------------------------------------------------------------
module des_rkg_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  des_rkg_pkg::halves_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output des_rkg_pkg::halves_t pop_data
);
    import des_rkg_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    halves_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/des_rkg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round key generator back end
// Rotates halves (not in decrypt round one) and registers each PC-2 round key.
// ----------------------------------------------------------------------------
`include "des_round_key_generator_core_defines.svh"

module des_rkg_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    queue_not_empty,
    input  des_rkg_pkg::halves_t    queue_data,
    output logic                    pop,
    output logic                    subkey_valid,
    input  logic                    subkey_stall,
    output des_rkg_pkg::subkey_item_t subkey_data
);
    import des_rkg_pkg::*;

    logic         busy_reg;
    logic         dec_reg;
    round_idx_t   idx_reg;
    half_t        c_reg;
    half_t        d_reg;
    logic         out_valid_reg;
    subkey_item_t out_reg;

    logic         advance;
    logic         load;
    logic         is_last;
    round_idx_t   back_idx;
    logic         left_two;
    logic         right_two;
    half_t        c_next;
    half_t        d_next;

    assign advance   = busy_reg && (!out_valid_reg || !subkey_stall);
    assign is_last   = idx_reg == LAST_ROUND;
    assign load      = queue_not_empty && (!busy_reg || (advance && is_last));
    assign pop       = load;
    assign back_idx  = ~idx_reg + round_idx_t'(1);
    assign left_two  = DOUBLE_SHIFT[idx_reg];
    assign right_two = DOUBLE_SHIFT[back_idx];

    always_comb
    begin
        if (!dec_reg)
        begin
            c_next = rot_left(c_reg, left_two);
            d_next = rot_left(d_reg, left_two);
        end
        else if (idx_reg == '0)
        begin
            c_next = c_reg;
            d_next = d_reg;
        end
        else
        begin
            c_next = rot_right(c_reg, right_two);
            d_next = rot_right(d_reg, right_two);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!subkey_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + round_idx_t'(1);
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.round_key   <= pc2({c_next, d_next});
            out_reg.round_index <= idx_reg;
            out_reg.last        <= is_last;
        end
        if (load)
        begin
            c_reg   <= queue_data.c;
            d_reg   <= queue_data.d;
            dec_reg <= queue_data.decrypt;
        end
        else if (advance)
        begin
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

    assign subkey_valid = out_valid_reg;
    assign subkey_data  = out_reg;

    `DRKG_ASSERT(a_last_on_final_round,
        out_valid_reg |-> (out_reg.last == (out_reg.round_index == LAST_ROUND)),
        "last marker does not match the final round index")
    `DRKG_ASSERT(a_rounds_in_order,
        (out_valid_reg && !subkey_stall && !out_reg.last) |=>
            (out_valid_reg && out_reg.round_index == $past(out_reg.round_index) + 4'd1),
        "round keys of one transaction are not delivered in consecutive order")
    `DRKG_ASSERT_ALWAYS(a_idle_index_zero,
        !busy_reg |-> (idx_reg == '0),
        "round counter is not at zero while the round engine is idle")

endmodule

// File: design/des_round_key_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES round key generator core
// Expands one DES key into its sixteen 48-bit round keys.
// ----------------------------------------------------------------------------
// Usage:
// A key transaction carries a 64-bit key and a decrypt flag. Each accepted
// key produces sixteen subkey transactions: K1 to K16 when decrypt is low,
// K16 down to K1 when it is high, each with its round index and a last flag
// on the sixteenth.
// The front end registers PC-1 of the key and passes the halves into a
// queue of QUEUE_DEPTH entries; the round engine rotates the halves once per
// cycle while the output is not stalled and registers each PC-2 result.
// After a key is accepted, its halves pass the front register, the queue and
// the engine registers, and one round key follows every cycle while the
// receiver does not stall. The single rotation engine expands one key at a
// time; further keys are taken and queued meanwhile.
// When subkey_stall is high the round key on the output holds and the engine
// waits; key_stall rises once the front register and queue are full.
// Reset clears all valid state; no transaction is pending afterwards.
// ----------------------------------------------------------------------------
module des_round_key_generator_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      key_valid,
    output logic                      key_stall,
    input  des_rkg_pkg::key_item_t    key_data,
    output logic                      subkey_valid,
    input  logic                      subkey_stall,
    output des_rkg_pkg::subkey_item_t subkey_data
);
    import des_rkg_pkg::*;

    logic    push;
    logic    queue_full;
    halves_t push_data;
    logic    pop;
    logic    queue_not_empty;
    halves_t pop_data;

    des_rkg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key_data   (key_data),
        .push       (push),
        .queue_full (queue_full),
        .push_data  (push_data)
    );

    des_rkg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    des_rkg_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_data      (pop_data),
        .pop             (pop),
        .subkey_valid    (subkey_valid),
        .subkey_stall    (subkey_stall),
        .subkey_data     (subkey_data)
    );

endmodule

// File: test/des_subkey_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DES subkey checker
// Watches the key and subkey channels of the round key generator. Each
// accepted key transaction is expanded into its sixteen expected round keys,
// and each accepted subkey transaction is compared field by field against
// the oldest expected one. Mismatches and unexpected transactions are counted.
// ----------------------------------------------------------------------------
module des_subkey_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      key_valid,
    input  logic                      key_stall,
    input  des_rkg_pkg::key_item_t    key_data,
    input  logic                      subkey_valid,
    input  logic                      subkey_stall,
    input  des_rkg_pkg::subkey_item_t subkey_data,
    output int                        error_count,
    output int                        pending_count,
    output int                        key_count,
    output int                        decrypt_count,
    output int                        subkey_count
);
    import des_rkg_pkg::*;

    localparam int KEY_SELECT [56] = '{
        57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
    };

    localparam int SUBKEY_SELECT [48] = '{
        14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
    };

    localparam int SHIFT_AMOUNT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    subkey_item_t expected_subkeys [$];
    int           mismatches = 0;
    int           keys_seen = 0;
    int           decrypts_seen = 0;
    int           subkeys_seen = 0;

    function automatic logic [47:0] select_subkey(input logic [27:0] c, input logic [27:0] d);
        logic [55:0] joined;
        logic [47:0] rk;
        joined = {c, d};
        for (int j = 0; j < 48; j++)
        begin
            rk[47-j] = joined[56-SUBKEY_SELECT[j]];
        end
        return rk;
    endfunction

    function automatic void expand_key_schedule(input key_item_t item);
        logic [55:0]  cd;
        logic [27:0]  c;
        logic [27:0]  d;
        int           s;
        subkey_item_t sk;
        for (int i = 0; i < 56; i++)
        begin
            cd[55-i] = item.key[64-KEY_SELECT[i]];
        end
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++)
        begin
            if (!item.decrypt)
            begin
                s = SHIFT_AMOUNT[r];
                c = (c << s) | (c >> (28 - s));
                d = (d << s) | (d >> (28 - s));
            end
            else if (r > 0)
            begin
                s = SHIFT_AMOUNT[16-r];
                c = (c >> s) | (c << (28 - s));
                d = (d >> s) | (d << (28 - s));
            end
            sk.round_key   = select_subkey(c, d);
            sk.round_index = round_idx_t'(r);
            sk.last        = (r == 15);
            expected_subkeys.push_back(sk);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_subkeys.delete();
        end
        else
        begin
            if (key_valid && !key_stall)
            begin
                expand_key_schedule(key_data);
                keys_seen++;
                if (key_data.decrypt)
                begin
                    decrypts_seen++;
                end
            end
            if (subkey_valid && !subkey_stall)
            begin
                subkeys_seen++;
                if (expected_subkeys.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected subkey transaction, actual key %h index %0d last %0b",
                             $time, subkey_data.round_key, subkey_data.round_index,
                             subkey_data.last);
                end
                else
                begin
                    subkey_item_t exp_sk;
                    exp_sk = expected_subkeys.pop_front();
                    if (subkey_data.round_key !== exp_sk.round_key)
                    begin
                        mismatches++;
                        $display("%0t: round_key mismatch, expected %h actual %h",
                                 $time, exp_sk.round_key, subkey_data.round_key);
                    end
                    if (subkey_data.round_index !== exp_sk.round_index)
                    begin
                        mismatches++;
                        $display("%0t: round_index mismatch, expected %0d actual %0d",
                                 $time, exp_sk.round_index, subkey_data.round_index);
                    end
                    if (subkey_data.last !== exp_sk.last)
                    begin
                        mismatches++;
                        $display("%0t: last mismatch, expected %0b actual %0b",
                                 $time, exp_sk.last, subkey_data.last);
                    end
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_subkeys.size();
        key_count     <= keys_seen;
        decrypt_count <= decrypts_seen;
        subkey_count  <= subkeys_seen;
    end

endmodule

// File: test/tb_des_round_key_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the DES round key generator core
// Sends a directed set of keys (extremes, parity-only differences, weak keys
// and a well-known test key in both directions) followed by random keys in
// several phases of sender gaps and receiver stalls. A separate checker
// predicts every round key and compares each subkey transaction.
// ----------------------------------------------------------------------------
module tb_des_round_key_generator_core;
    import des_rkg_pkg::*;

    localparam int          IDLE_LIMIT  = 2000;
    localparam logic [63:0] PARITY_BITS = 64'h0101_0101_0101_0101;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         key_valid = 1'b0;
    logic         key_stall;
    key_item_t    key_data = '0;
    logic         subkey_valid;
    logic         subkey_stall = 1'b0;
    subkey_item_t subkey_data;

    int error_count;
    int pending_count;
    int key_count;
    int decrypt_count;
    int subkey_count;

    int stall_pct = 0;
    int stall_run = 0;
    int burst_left = 0;
    int gap_max = 0;
    int idle_cycles = 0;

    logic [63:0] last_key = '0;

    des_round_key_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key_data     (key_data),
        .subkey_valid (subkey_valid),
        .subkey_stall (subkey_stall),
        .subkey_data  (subkey_data)
    );

    des_subkey_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .key_data      (key_data),
        .subkey_valid  (subkey_valid),
        .subkey_stall  (subkey_stall),
        .subkey_data   (subkey_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .key_count     (key_count),
        .decrypt_count (decrypt_count),
        .subkey_count  (subkey_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            subkey_stall <= 1'b1;
            stall_run    <= stall_run - 1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            subkey_stall <= 1'b1;
            stall_run    <= $urandom_range(5);
        end
        else
        begin
            subkey_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((key_valid && !key_stall) || (subkey_valid && !subkey_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_key(input logic [63:0] k, input logic dec);
        int gap;
        key_valid <= 1'b1;
        key_data  <= {k, dec};
        last_key  = k;
        @(posedge clk);
        while (key_stall)
        begin
            @(posedge clk);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 8);
            if (gap_max > 0)
            begin
                gap = $urandom_range(1, gap_max);
                key_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        key_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [63:0] k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys, back to back.
        send_key(64'h0000_0000_0000_0000, 1'b0);
        send_key(64'h0000_0000_0000_0000, 1'b1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_key(PARITY_BITS, 1'b0);
        send_key(PARITY_BITS, 1'b1);
        send_key(~PARITY_BITS, 1'b0);
        send_key(~PARITY_BITS, 1'b1);
        send_key(64'h1334_5779_9BBC_DFF1, 1'b0);
        send_key(64'h1334_5779_9BBC_DFF1, 1'b1);
        send_key(64'h1334_5779_9BBC_DFF1 ^ PARITY_BITS, 1'b0);
        send_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_key(64'h5555_5555_5555_5555, 1'b1);
        send_key(64'h1F1F_1F1F_0E0E_0E0E, 1'b0);
        send_key(64'hE0E0_E0E0_F1F1_F1F1, 1'b1);
        send_key(64'h8000_0000_0000_0000, 1'b0);
        send_key(64'h0000_0000_0000_0002, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_max   = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    gap_max   = 4;
                    stall_pct <= 30;
                end
                2:
                begin
                    gap_max   = 12;
                    stall_pct <= 70;
                end
                default:
                begin
                    gap_max   = 3;
                    stall_pct <= 15;
                end
            endcase
            for (int n = 0; n < 102; n++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    k = last_key ^ (PARITY_BITS & {$urandom, $urandom});
                end
                else
                begin
                    k = {$urandom, $urandom};
                end
                send_key(k, 1'($urandom_range(1)));
            end
            wait_drained();
        end

        stall_pct <= 0;
        repeat (40) @(posedge clk);

        $display("Covered %0d keys (%0d for decryption) and %0d round keys,", key_count,
                 decrypt_count, subkey_count);
        $display("with back-to-back keys, sender gaps and receiver stalls of varying density.");
        if (error_count == 0 && pending_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d round keys still expected", error_count,
                     pending_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
